### sv/ils_pkg.sv
// Shared types and constants for the indexed list store.
`default_nettype none

package ils_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int DATA_W    = 32;
   localparam int OP_W      = 3;
   localparam int POS_W     = 6;
   localparam int LEN_W     = 7;
   localparam int ST_W      = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT  = 3'd0,
      OP_POP_FRONT   = 3'd1,
      OP_APPEND      = 3'd2,
      OP_POP_BACK    = 3'd3,
      OP_INSERT_AFTER = 3'd4,
      OP_DELETE_AT   = 3'd5,
      OP_READ_AT     = 3'd6,
      OP_COUNT       = 3'd7
   } req_op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADIDX = 2'd3
   } status_type;

   // What every cell of the chain does this cycle.
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type cell_op;
      logic        rd_en;
      status_type  status;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

### sv/ils_cell.sv
// One storage cell of the list chain.
`default_nettype none

module ils_cell
   import ils_pkg::*;
#(
   parameter int IDX_W = 6,
   parameter int INDEX = 0
) (
   input  wire logic              clock,
   input  wire cell_op_type       cell_op,
   input  wire logic [IDX_W-1:0]  at,
   input  wire logic [DATA_W-1:0] new_value,
   input  wire logic [DATA_W-1:0] left_in,
   input  wire logic [DATA_W-1:0] right_in,
   output logic      [DATA_W-1:0] value_out,
   output logic      [DATA_W-1:0] read_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (cell_op)
         CELL_INSERT: begin
            if (MY_IDX > at) begin
               value_in = left_in;
            end else if (MY_IDX == at) begin
               value_in = new_value;
            end
         end
         CELL_REMOVE: begin
            if (MY_IDX >= at) begin
               value_in = right_in;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;
   // gated tap for the OR-combine read path
   assign read_out  = (MY_IDX == at) ? value_ff : '0;

endmodule

`default_nettype wire

### sv/ils_ctrl.sv
// Operation decode and element count for the list chain.
`default_nettype none

module ils_ctrl
   import ils_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [OP_W-1:0]              req_type,
   input  wire logic [POS_W-1:0]             position,
   output ctrl_cmd_type                      cmd,
   output logic [$clog2(DEPTH)-1:0]          at,
   output logic [$clog2(DEPTH+1)-1:0]        occupancy
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0] occ_ff;
   logic [CNT_W-1:0] occ_in;
   req_op_type       op;
   logic             full;
   logic             empty;
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] occ_x;
   logic [CMP_W-1:0] last_x;
   logic [CMP_W-1:0] at_w;
   ctrl_cmd_type     cmd_w;

   always_comb begin
      op     = req_op_type'(req_type);
      full   = (occ_ff == CNT_W'(DEPTH));
      empty  = (occ_ff == '0);
      pos_x  = CMP_W'(position);
      occ_x  = CMP_W'(occ_ff);
      last_x = occ_x - CMP_W'(1);
      at_w   = '0;
      cmd_w.cell_op = CELL_HOLD;
      cmd_w.rd_en   = 1'b0;
      cmd_w.status  = ST_OK;

      unique case (op)
         OP_PUSH_FRONT: begin
            if (full) cmd_w.status = ST_FULL;
            else cmd_w.cell_op = CELL_INSERT;
         end
         OP_POP_FRONT: begin
            if (empty) begin
               cmd_w.status = ST_EMPTY;
            end else begin
               cmd_w.cell_op = CELL_REMOVE;
               cmd_w.rd_en   = 1'b1;
            end
         end
         OP_APPEND: begin
            if (full) begin
               cmd_w.status = ST_FULL;
            end else begin
               cmd_w.cell_op = CELL_INSERT;
               at_w          = occ_x;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               cmd_w.status = ST_EMPTY;
            end else begin
               cmd_w.cell_op = CELL_REMOVE;
               cmd_w.rd_en   = 1'b1;
               at_w          = last_x;
            end
         end
         OP_INSERT_AFTER: begin
            if (full) begin
               cmd_w.status = ST_FULL;
            end else begin
               cmd_w.cell_op = CELL_INSERT;
               // clamp to the last element; empty list lands at the front
               if (empty) at_w = '0;
               else if (pos_x < last_x) at_w = CMP_W'(pos_x + CMP_W'(1));
               else at_w = occ_x;
            end
         end
         OP_DELETE_AT: begin
            if (empty) begin
               cmd_w.status = ST_EMPTY;
            end else if (pos_x >= occ_x) begin
               cmd_w.status = ST_BADIDX;
            end else begin
               cmd_w.cell_op = CELL_REMOVE;
               cmd_w.rd_en   = 1'b1;
               at_w          = pos_x;
            end
         end
         OP_READ_AT: begin
            if (empty) begin
               cmd_w.status = ST_EMPTY;
            end else if (pos_x >= occ_x) begin
               cmd_w.status = ST_BADIDX;
            end else begin
               cmd_w.rd_en = 1'b1;
               at_w        = pos_x;
            end
         end
         default: begin
            cmd_w.status = ST_OK;
         end
      endcase

      if (!accept) cmd_w.cell_op = CELL_HOLD;

      occ_in = occ_ff;
      if (cmd_w.cell_op == CELL_INSERT) occ_in = occ_ff + CNT_W'(1);
      else if (cmd_w.cell_op == CELL_REMOVE) occ_in = occ_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign cmd       = cmd_w;
   assign at        = IDX_W'(at_w);
   assign occupancy = occ_ff;

endmodule

`default_nettype wire

### sv/indexed_list_store.sv
// Top level of the indexed list store: decode, cell chain and response register.
//
//   port group   dir   handshake              payload
//   req_         in    req_valid/req_stall    req_type, req_data_in, req_position
//   rsp_         out   rsp_valid/rsp_stall    rsp_data_out, rsp_length, rsp_status
//
// All cells of the chain shift toward or away from the front in the same clock,
// so one word per cycle is taken while req_stall is low. The response comes
// from the response register in the cycle after acceptance.
// The request side stalls only while a response is held by rsp_stall.
// Synchronous reset empties the list; cell contents are not cleared.
`default_nettype none

module indexed_list_store
   import ils_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [OP_W-1:0]          req_type,
   input  wire logic signed [DATA_W-1:0] req_data_in,
   input  wire logic [POS_W-1:0]         req_position,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_data_out,
   output logic [LEN_W-1:0]              rsp_length,
   output logic [ST_W-1:0]               rsp_status
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic               accept;
   ctrl_cmd_type       cmd;
   logic [IDX_W-1:0]   at;
   logic [CNT_W-1:0]   occupancy;
   logic [DATA_W-1:0]  value_w [DEPTH];
   logic [DATA_W-1:0]  read_w  [DEPTH];
   logic [DATA_W-1:0]  rd_or;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [DATA_W-1:0]  data_out_ff;
   logic [DATA_W-1:0]  data_out_in;
   status_type         status_ff;

   // one response word in flight; hold off new requests while it is stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   ils_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_type  (req_type),
      .position  (req_position),
      .cmd       (cmd),
      .at        (at),
      .occupancy (occupancy)
   );

   // cell 0 is the front; insert shifts toward the back, remove toward the front
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = value_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w = value_w[i];
      end else begin : g_mid_r
         assign right_w = value_w[i+1];
      end

      ils_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .cell_op   (cmd.cell_op),
         .at        (at),
         .new_value (req_data_in),
         .left_in   (left_w),
         .right_in  (right_w),
         .value_out (value_w[i]),
         .read_out  (read_w[i])
      );
   end

   // only the addressed cell drives a nonzero tap
   always_comb begin
      rd_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_or = rd_or | read_w[i];
      end
   end

   assign data_out_in  = cmd.rd_en ? rd_or : '0;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_out_ff <= data_out_in;
         status_ff   <= cmd.status;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = data_out_ff;
   // count is stable while a response waits, since no request is taken then
   assign rsp_length   = LEN_W'(occupancy);
   assign rsp_status   = status_ff;

endmodule

`default_nettype wire

### sv/ils_checker.sv
// Port-level checks for the indexed list store, bound to the top level.
`default_nettype none

module ils_checker
   import ils_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic signed [DATA_W-1:0] rsp_data_out,
   input wire logic [LEN_W-1:0]         rsp_length,
   input wire logic [ST_W-1:0]          rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out))
      else $error("response dropped or changed while stalled");

   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with no pending response");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_length == '0)
      else $error("empty status with nonzero length");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_data_out == '0)
      else $error("failed request returned data");

endmodule

bind indexed_list_store ils_checker u_ils_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_data_out (rsp_data_out),
   .rsp_length   (rsp_length),
   .rsp_status   (rsp_status)
);

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the indexed list store: directed and random list traffic.
`default_nettype none

module tb;
   import ils_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH    = DEPTH_DEF;
   localparam int RANDOM_ITEMS  = 1080;   // random words after the directed part
   localparam int TAIL_ITEMS    = 150;    // last words run with no idling on either side
   localparam int LONG_HOLD_AT  = 400;    // response count that starts the long hold
   localparam int LONG_HOLD_LEN = 40;     // cycles the receiver holds off
   localparam int SETTLE_AT     = 700;    // word index where the sender waits for all results
   localparam int DRAIN_CYCLES  = 10;     // quiet cycles after the last response before the run ends
   localparam int STUCK_LIMIT   = 2000;   // cycles with no word moving on either channel
   localparam int MAX_REPORTS   = 10;

   // Traffic shaping for the random part: fill toward full, drain toward
   // empty, or a flat mix of all operations.
   typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_type;

   typedef struct {
      req_op_type               op;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         pos;
      bit                       settle_first;   // hold off until nothing is outstanding
   } list_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [LEN_W-1:0]         len;
      status_type               st;
   } list_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OP_W-1:0]          req_type = '0;
   logic signed [DATA_W-1:0] req_data_in = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic [LEN_W-1:0]         rsp_length;
   logic [ST_W-1:0]          rsp_status;

   list_req_type             pending_reqs[$];     // words not yet offered
   list_rsp_type             awaited_results[$];  // predicted responses, oldest first
   logic signed [DATA_W-1:0] list_model[$];       // predicted list contents, front first

   int  total_reqs;
   int  reqs_taken;
   int  rsp_seen;
   int  err_cnt;
   int  send_gap;
   int  stall_left;
   int  long_hold_left;
   bit  long_hold_done;
   bit  quiet_tail;
   int  stuck_cycles;
   int  gen_len;   // list length as the generator sees it, only to aim positions

   indexed_list_store #(
      .DEPTH(LIST_DEPTH)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_data_in  (req_data_in),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data_out (rsp_data_out),
      .rsp_length   (rsp_length),
      .rsp_status   (rsp_status)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Predictor: applies one operation to the list image and returns what the
   // block must answer. A failing request leaves the image untouched.
   function automatic list_rsp_type apply_list_op(req_op_type op,
                                                  logic signed [DATA_W-1:0] val,
                                                  logic [POS_W-1:0] pos);
      list_rsp_type r;
      int unsigned  n;
      int unsigned  at;
      n      = list_model.size();
      r.data = '0;
      r.st   = ST_OK;
      case (op)
         OP_PUSH_FRONT: begin
            if (n >= LIST_DEPTH) r.st = ST_FULL;
            else list_model.push_front(val);
         end
         OP_POP_FRONT: begin
            if (n == 0) r.st = ST_EMPTY;
            else r.data = list_model.pop_front();
         end
         OP_APPEND: begin
            if (n >= LIST_DEPTH) r.st = ST_FULL;
            else list_model.push_back(val);
         end
         OP_POP_BACK: begin
            if (n == 0) r.st = ST_EMPTY;
            else r.data = list_model.pop_back();
         end
         OP_INSERT_AFTER: begin
            // position past the last element clamps to it; empty list just takes the value
            if (n >= LIST_DEPTH) begin
               r.st = ST_FULL;
            end else if (n == 0) begin
               list_model.push_back(val);
            end else begin
               at = (pos < n - 1) ? pos + 1 : n;
               list_model.insert(at, val);
            end
         end
         OP_DELETE_AT: begin
            if (n == 0) begin
               r.st = ST_EMPTY;
            end else if (pos >= n) begin
               r.st = ST_BADIDX;
            end else begin
               r.data = list_model[pos];
               list_model.delete(pos);
            end
         end
         OP_READ_AT: begin
            if (n == 0) r.st = ST_EMPTY;
            else if (pos >= n) r.st = ST_BADIDX;
            else r.data = list_model[pos];
         end
         default: ;   // count: nothing moves
      endcase
      r.len = LEN_W'(list_model.size());
      return r;
   endfunction

   task automatic add_req(req_op_type op, logic signed [DATA_W-1:0] val,
                          logic [POS_W-1:0] pos);
      list_req_type it;
      it.op           = op;
      it.value        = val;
      it.pos          = pos;
      it.settle_first = 1'b0;
      pending_reqs.push_back(it);
   endtask

   // One random word shaped by the phase. Positions lean toward live indexes
   // so delete and read mostly hit, with the full range still covered.
   function automatic list_req_type random_req(phase_kind_type kind);
      list_req_type it;
      int           r;
      int           grp;   // 0 grows the list, 1 shrinks it, 2 reads or counts, 3 picks any operation
      r = $urandom_range(0, 99);
      case (kind)
         PH_FILL:  grp = (r < 80) ? 0 : (r < 88) ? 2 : 1;
         PH_DRAIN: grp = (r < 75) ? 1 : (r < 85) ? 2 : 0;
         default:  grp = 3;
      endcase
      case (grp)
         0: begin
            case ($urandom_range(0, 2))
               0:       it.op = OP_PUSH_FRONT;
               1:       it.op = OP_APPEND;
               default: it.op = OP_INSERT_AFTER;
            endcase
         end
         1: begin
            case ($urandom_range(0, 2))
               0:       it.op = OP_POP_FRONT;
               1:       it.op = OP_POP_BACK;
               default: it.op = OP_DELETE_AT;
            endcase
         end
         2:       it.op = ($urandom_range(0, 3) == 0) ? OP_COUNT : OP_READ_AT;
         default: it.op = req_op_type'($urandom_range(0, 7));
      endcase
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0:       it.value = 32'sh8000_0000;
            1:       it.value = 32'sh7fff_ffff;
            2:       it.value = '0;
            default: it.value = -32'sd1;
         endcase
      end else begin
         it.value = $urandom;
      end
      if (gen_len > 0 && $urandom_range(0, 2) != 0)
         it.pos = POS_W'($urandom_range(0, gen_len - 1));
      else
         it.pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
      it.settle_first = 1'b0;
      // track length only, so later positions can aim at live elements
      case (it.op)
         OP_PUSH_FRONT, OP_APPEND, OP_INSERT_AFTER: if (gen_len < LIST_DEPTH) gen_len++;
         OP_POP_FRONT, OP_POP_BACK:                 if (gen_len > 0) gen_len--;
         OP_DELETE_AT:                              if (it.pos < gen_len) gen_len--;
         default: ;
      endcase
      return it;
   endfunction

   // Stimulus, reset and end of run.
   initial begin : main_seq
      phase_kind_type kind;
      int             span;
      int             k;
      list_req_type   it;

      // Directed part: empty-list errors, insert into empty, pop back of the
      // only element, append to empty, clamped insert, bad indexes, extremes.
      add_req(OP_COUNT,        '0,              '0);
      add_req(OP_POP_FRONT,    '0,              '0);
      add_req(OP_POP_BACK,     '0,              '0);
      add_req(OP_DELETE_AT,    '0,              '0);
      add_req(OP_READ_AT,      '0,              6'd63);
      add_req(OP_INSERT_AFTER, 32'sh7fff_ffff,  6'd63);
      add_req(OP_POP_BACK,     '0,              '0);
      add_req(OP_APPEND,       32'sh8000_0000,  '0);
      add_req(OP_PUSH_FRONT,   -32'sd1,         6'd63);
      add_req(OP_APPEND,       '0,              '0);
      add_req(OP_INSERT_AFTER, 32'sh5a5a_5a5a,  6'd63);
      add_req(OP_INSERT_AFTER, 32'sha5a5_a5a5,  '0);
      add_req(OP_READ_AT,      '0,              '0);
      add_req(OP_READ_AT,      '0,              6'd4);
      add_req(OP_READ_AT,      '0,              6'd5);
      add_req(OP_DELETE_AT,    '0,              6'd63);
      add_req(OP_DELETE_AT,    '0,              6'd2);
      add_req(OP_POP_FRONT,    '0,              '0);
      add_req(OP_POP_BACK,     '0,              '0);
      add_req(OP_COUNT,        32'sh7fff_ffff,  6'd63);
      add_req(OP_DELETE_AT,    '0,              '0);
      add_req(OP_POP_FRONT,    '0,              '0);

      // Random part in phases of 40 to 120 words; fill and drain phases
      // push the list against full and empty again and again.
      gen_len = 0;
      k       = 0;
      while (k < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0:       kind = PH_FILL;
            1:       kind = PH_DRAIN;
            default: kind = PH_MIX;
         endcase
         span = $urandom_range(40, 120);
         repeat (span) begin
            if (k < RANDOM_ITEMS) begin
               it = random_req(kind);
               pending_reqs.push_back(it);
               k++;
            end
         end
      end
      // one point where the sender waits for every response to come back
      pending_reqs[SETTLE_AT].settle_first = 1'b1;
      total_reqs = pending_reqs.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (reqs_taken < total_reqs || awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_cnt == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Driver: offers one word at a time from the pending queue and holds it
   // steady while stalled. An accepted word is run through the predictor at
   // the edge it is taken, so expectations stay in acceptance order.
   always @(posedge clock) begin : drive_proc
      list_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.push_back(apply_list_op(req_op_type'(req_type),
                                                    req_data_in, req_position));
            reqs_taken++;
         end
         quiet_tail = pending_reqs.size() < TAIL_ITEMS;
         if (req_valid && req_stall) begin
            // word still waiting: payload and valid stay as they are
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() == 0 ||
                      (pending_reqs[0].settle_first && awaited_results.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            // start an idle burst, this cycle included
            send_gap = $urandom_range(1, 7) - 1;
            req_valid <= 1'b0;
         end else begin
            nxt = pending_reqs.pop_front();
            req_valid    <= 1'b1;
            req_type     <= nxt.op;
            req_data_in  <= nxt.value;
            req_position <= nxt.pos;
         end
      end
   end

   // Monitor: checks every accepted response against the oldest expectation
   // and drives the receiver's stall, including one long hold that backs the
   // block up until it stalls its request side.
   always @(posedge clock) begin : check_proc
      list_rsp_type exp_rsp;
      if (reset) begin
         rsp_stall     <= 1'b0;
         stall_left     = 0;
         long_hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (awaited_results.size() == 0) begin
               if (err_cnt < MAX_REPORTS)
                  $display("%0t: response with nothing outstanding: data %0d len %0d st %0d",
                           $time, rsp_data_out, rsp_length, rsp_status);
               err_cnt++;
            end else begin
               exp_rsp = awaited_results.pop_front();
               if (exp_rsp.data !== rsp_data_out || exp_rsp.len !== rsp_length ||
                   exp_rsp.st !== status_type'(rsp_status)) begin
                  if (err_cnt < MAX_REPORTS)
                     $display("%0t: response %0d mismatch: data %0d/%0d len %0d/%0d st %0d/%0d",
                              $time, rsp_seen, exp_rsp.data, rsp_data_out,
                              exp_rsp.len, rsp_length, exp_rsp.st, rsp_status);
                  err_cnt++;
               end
            end
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_stall <= 1'b1;
         end else if (!long_hold_done && rsp_seen >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD_LEN - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: ends the run if no word moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
